>>> src/tci_pkg.sv
// shared types, constants and blend table helper for the throttle curve interpolator
`default_nettype none
package tci_pkg;

   localparam int MAX_POINTS_DEFAULT      = 8;
   localparam int INPUT_MAX_DEFAULT       = 1023;
   localparam int OUTPUT_MAX_DEFAULT      = 32767;
   localparam int COS_TABLE_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURVE_MODE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINT_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_POINTS_LOW  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_POINTS_HIGH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_POINTS_LOW  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_POINTS_HIGH = 3'd5;

   localparam logic [63:0] X_POINTS_LOW_RESET = 64'h0000_0000_03FF_0000;
   localparam logic [63:0] Y_POINTS_LOW_RESET = 64'h0000_0000_7FFF_0000;
   localparam logic [3:0]  POINT_COUNT_RESET  = 4'd2;

   localparam logic CURVE_LINEAR = 1'b0;
   localparam logic CURVE_COSINE = 1'b1;

   // blend table generation, all elaboration time
   localparam longint unsigned PI_Q28       = 64'd843314857;
   localparam int              TRIG_BITS    = 28;
   localparam int              TAYLOR_TERMS = 14;
   localparam longint unsigned TAYLOR_DIVISOR [1:TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756};

   typedef struct packed {
      logic        mode;
      logic [3:0]  count;
      logic [63:0] x_low;
      logic [63:0] x_high;
      logic [63:0] y_low;
      logic [63:0] y_high;
   } curve_cfg_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic        direct;
      logic [15:0] direct_y;
      logic        mode;
      logic [15:0] dx;
      logic [15:0] xd;
      logic [15:0] y_lo;
      logic [15:0] y_hi;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_DIV,
      BK_LOOKUP,
      BK_WMUL,
      BK_WSUM
   } back_state_type;

   // weight (1-cos(t))/2 in Q16 for angle t in Q28
   function automatic logic [16:0] blend_weight(longint unsigned t);
      longint unsigned t2;
      longint unsigned term;
      longint unsigned w;
      longint          c;
      longint          v;
      t2   = (t * t) >> TRIG_BITS;
      term = 64'd1 << TRIG_BITS;
      c    = longint'(term);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = (term * t2) >> TRIG_BITS;
         term = term / TAYLOR_DIVISOR[n];
         if (n % 2 == 1) begin
            c = c - longint'(term);
         end else begin
            c = c + longint'(term);
         end
      end
      v = (longint'(1) << TRIG_BITS) - c;
      if (v < 0) begin
         v = 0;
      end
      w = (longint'(v) + 64'd4096) >> 13;
      if (w > 64'd65536) begin
         w = 64'd65536;
      end
      return w[16:0];
   endfunction

endpackage
`default_nettype wire

>>> src/tci_front.sv
// front end: input clamp, deadzone and segment search
`default_nettype none
module tci_front #(
   parameter int MAX_POINTS = tci_pkg::MAX_POINTS_DEFAULT,
   parameter int INPUT_MAX  = tci_pkg::INPUT_MAX_DEFAULT
) (
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [9:0]            req_throttle_position,
   input  wire tci_pkg::curve_cfg_type cfg,
   input  wire logic                  queue_full,
   output logic                       queue_push,
   output tci_pkg::item_type          queue_item
);

   logic [15:0] pos;
   logic [3:0]  count;
   logic [15:0] px [8];
   logic [15:0] py [8];
   logic        found;
   logic [2:0]  seg;
   logic [2:0]  seg_next;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         px[i]   = cfg.x_low[16*i +: 16];
         px[i+4] = cfg.x_high[16*i +: 16];
         py[i]   = cfg.y_low[16*i +: 16];
         py[i+4] = cfg.y_high[16*i +: 16];
      end
   end

   always_comb begin
      pos = {6'd0, req_throttle_position};
      if (32'(pos) > INPUT_MAX) begin
         pos = 16'(INPUT_MAX);
      end
      count = cfg.count;
      if (count < 4'd2) begin
         count = 4'd2;
      end
      if (32'(count) > MAX_POINTS) begin
         count = 4'(MAX_POINTS);
      end
      found = 1'b0;
      seg   = 3'd0;
      for (int i = 0; i < MAX_POINTS; i++) begin
         if ((4'(i) < count) && (px[i] < pos)) begin
            found = 1'b1;
            seg   = 3'(i);
         end
      end
      seg_next = seg + 3'd1;
   end

   always_comb begin
      queue_item.direct   = 1'b1;
      queue_item.direct_y = 16'd0;
      queue_item.mode     = cfg.mode;
      queue_item.dx       = pos - px[seg];
      queue_item.xd       = px[seg_next] - px[seg];
      queue_item.y_lo     = py[seg];
      queue_item.y_hi     = py[seg_next];
      if (pos < px[0]) begin
         queue_item.direct_y = 16'd0;
      end else if (!found) begin
         queue_item.direct_y = py[0];
      end else if ({1'b0, seg} == count - 4'd1) begin
         queue_item.direct_y = py[seg];
      end else begin
         queue_item.direct = 1'b0;
      end
   end

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

endmodule
`default_nettype wire

>>> src/tci_queue.sv
// short queue of classified words between front and back
`default_nettype none
module tci_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tci_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output tci_pkg::item_type      head_item
);

   localparam int PW = $clog2(tci_pkg::QUEUE_DEPTH);

   tci_pkg::item_type           slot_ff [tci_pkg::QUEUE_DEPTH];
   logic [PW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [PW:0]                 fill_ff, fill_in;
   logic                        do_push;
   logic                        do_pop;

   assign full      = fill_ff == (PW+1)'(tci_pkg::QUEUE_DEPTH);
   assign empty     = fill_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> src/tci_back.sv
// back end: multiply, serial divide, blend lookup and result register
`default_nettype none
module tci_back #(
   parameter int OUTPUT_MAX      = tci_pkg::OUTPUT_MAX_DEFAULT,
   parameter int COS_TABLE_DEPTH = tci_pkg::COS_TABLE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire tci_pkg::item_type queue_item,
   output logic                   queue_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [14:0]            rsp_drive_request
);

   localparam int KW = $clog2(COS_TABLE_DEPTH + 1);

   logic [16:0] blend_rom [COS_TABLE_DEPTH+1];

   for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_rom
      localparam longint unsigned ANGLE = (tci_pkg::PI_Q28 * g) / COS_TABLE_DEPTH;
      assign blend_rom[g] = tci_pkg::blend_weight(ANGLE);
   end

   tci_pkg::back_state_type state_ff, state_in;
   tci_pkg::item_type       cur_ff, cur_in;
   logic [32:0]             prod_a_ff, prod_a_in;
   logic [32:0]             prod_b_ff, prod_b_in;
   logic [15:0]             rem_ff, rem_in;
   logic [15:0]             dvd_ff, dvd_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [16:0]             w_ff, w_in;
   logic [14:0]             out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;

   logic [33:0] prod_sum;
   logic [16:0] trial;
   logic        trial_ge;
   logic [31:0] k_wide;
   logic [15:0] k_raw;
   logic [KW-1:0] k_sel;
   logic        finish;
   logic [15:0] finish_y;

   assign prod_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   assign trial    = {rem_ff, dvd_ff[15]};
   assign trial_ge = trial >= {1'b0, cur_ff.xd};
   assign k_wide   = 32'(dvd_ff) * 32'(COS_TABLE_DEPTH) + 32'd32768;
   assign k_raw    = k_wide[31:16];

   always_comb begin
      k_sel = KW'(k_raw);
      if (32'(k_raw) > COS_TABLE_DEPTH) begin
         k_sel = KW'(COS_TABLE_DEPTH);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      queue_pop    = 1'b0;
      finish       = 1'b0;
      finish_y     = 16'd0;
      case (state_ff)
         tci_pkg::BK_IDLE: begin
            if (!queue_empty && !out_valid_ff) begin
               queue_pop = 1'b1;
               cur_in    = queue_item;
               if (queue_item.direct) begin
                  finish   = 1'b1;
                  finish_y = queue_item.direct_y;
               end else begin
                  state_in = tci_pkg::BK_MUL;
               end
            end
         end
         tci_pkg::BK_MUL: begin
            cnt_in = 4'd0;
            if (cur_ff.mode == tci_pkg::CURVE_COSINE) begin
               // mu = (dx << 16) / xd
               rem_in   = cur_ff.dx;
               dvd_in   = 16'd0;
               state_in = tci_pkg::BK_DIV;
            end else begin
               prod_a_in = 33'(cur_ff.y_lo) * 33'(cur_ff.xd - cur_ff.dx);
               prod_b_in = 33'(cur_ff.y_hi) * 33'(cur_ff.dx);
               state_in  = tci_pkg::BK_SUM;
            end
         end
         tci_pkg::BK_SUM: begin
            // quotient fits 16 bits, so the upper half is already below xd
            rem_in   = prod_sum[31:16];
            dvd_in   = prod_sum[15:0];
            state_in = tci_pkg::BK_DIV;
         end
         tci_pkg::BK_DIV: begin
            rem_in = trial_ge ? 16'(trial - {1'b0, cur_ff.xd}) : trial[15:0];
            dvd_in = {dvd_ff[14:0], trial_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (cur_ff.mode == tci_pkg::CURVE_COSINE) begin
                  state_in = tci_pkg::BK_LOOKUP;
               end else begin
                  finish   = 1'b1;
                  finish_y = {dvd_ff[14:0], trial_ge};
                  state_in = tci_pkg::BK_IDLE;
               end
            end
         end
         tci_pkg::BK_LOOKUP: begin
            w_in     = blend_rom[k_sel];
            state_in = tci_pkg::BK_WMUL;
         end
         tci_pkg::BK_WMUL: begin
            prod_a_in = 33'(cur_ff.y_lo) * (33'd65536 - 33'(w_ff));
            prod_b_in = 33'(cur_ff.y_hi) * 33'(w_ff);
            state_in  = tci_pkg::BK_WSUM;
         end
         tci_pkg::BK_WSUM: begin
            finish   = 1'b1;
            finish_y = prod_sum[31:16];
            state_in = tci_pkg::BK_IDLE;
         end
         default: begin
            state_in = tci_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (finish) begin
         out_valid_in = 1'b1;
         out_in       = finish_y[14:0];
         if ({1'b0, finish_y} > 17'(OUTPUT_MAX)) begin
            out_in = 15'(OUTPUT_MAX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tci_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      cnt_ff    <= cnt_in;
      w_ff      <= w_in;
      out_ff    <= out_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_drive_request = out_ff;

endmodule
`default_nettype wire

>>> src/throttle_curve_interpolator_core.sv
// top level: curve registers, front end, queue and back end
//
//  channel  direction  handshake                 payload
//  req      in         req_push / req_full       req_throttle_position[9:0]
//  rsp      out        rsp_pop / rsp_empty       rsp_drive_request[14:0]
//  csr      in         csr_write_enable          csr_index[2:0], csr_data[63:0]
//
//  a word in the deadzone, on the first breakpoint or past the last point skips the arithmetic
//  linear: multiply, sum, 16-step serial divide; cosine: divide, blend lookup, multiply, sum
//  the back end starts a word only once the result register is free
//  synchronous active-high reset restores the default two-point ramp, linear mode
//  the queue takes up to two words while the back end is busy
`default_nettype none
module throttle_curve_interpolator_core #(
   parameter int MAX_POINTS      = tci_pkg::MAX_POINTS_DEFAULT,
   parameter int INPUT_MAX       = tci_pkg::INPUT_MAX_DEFAULT,
   parameter int OUTPUT_MAX      = tci_pkg::OUTPUT_MAX_DEFAULT,
   parameter int COS_TABLE_DEPTH = tci_pkg::COS_TABLE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [9:0]                           req_throttle_position,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [14:0]                               rsp_drive_request,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tci_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [tci_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   tci_pkg::curve_cfg_type cfg_ff, cfg_in;
   tci_pkg::item_type      front_item;
   tci_pkg::item_type      head_item;
   logic                   queue_full;
   logic                   queue_push;
   logic                   queue_empty;
   logic                   queue_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tci_pkg::CSR_CURVE_MODE:    cfg_in.mode   = csr_data[0];
            tci_pkg::CSR_POINT_COUNT:   cfg_in.count  = csr_data[3:0];
            tci_pkg::CSR_X_POINTS_LOW:  cfg_in.x_low  = csr_data;
            tci_pkg::CSR_X_POINTS_HIGH: cfg_in.x_high = csr_data;
            tci_pkg::CSR_Y_POINTS_LOW:  cfg_in.y_low  = csr_data;
            tci_pkg::CSR_Y_POINTS_HIGH: cfg_in.y_high = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= tci_pkg::CURVE_LINEAR;
         cfg_ff.count  <= tci_pkg::POINT_COUNT_RESET;
         cfg_ff.x_low  <= tci_pkg::X_POINTS_LOW_RESET;
         cfg_ff.x_high <= 64'd0;
         cfg_ff.y_low  <= tci_pkg::Y_POINTS_LOW_RESET;
         cfg_ff.y_high <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tci_front #(
      .MAX_POINTS (MAX_POINTS),
      .INPUT_MAX  (INPUT_MAX)
   ) u_front (
      .req_push              (req_push),
      .req_full              (req_full),
      .req_throttle_position (req_throttle_position),
      .cfg                   (cfg_ff),
      .queue_full            (queue_full),
      .queue_push            (queue_push),
      .queue_item            (front_item)
   );

   tci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   tci_back #(
      .OUTPUT_MAX      (OUTPUT_MAX),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_item        (head_item),
      .queue_pop         (queue_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_drive_request (rsp_drive_request)
   );

endmodule
`default_nettype wire

>>> dv/throttle_curve_interpolator_core_tb.sv
// testbench for the throttle curve interpolator core: directed table, then random curves
`timescale 1ns / 100ps
`default_nettype none
module throttle_curve_interpolator_core_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 50;
   localparam int HOLD_CYCLES    = 300;
   localparam int TABLE_DEPTH    = 256;
   localparam int DRIVE_MAX      = 32767;

   // indexes past the register list
   localparam logic [tci_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LOW  = 3'd6;
   localparam logic [tci_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   typedef enum logic [1:0] {ROW_WORD, ROW_WORD_KNOWN, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                         kind;
      logic [9:0]                           position;
      logic [14:0]                          known_drive;
      logic [tci_pkg::CSR_INDEX_WIDTH-1:0]  index;
      logic [63:0]                          data;
   } row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_push;
   logic                                 req_full;
   logic [9:0]                           req_throttle_position;
   logic                                 rsp_empty;
   logic                                 rsp_pop;
   logic [14:0]                          rsp_drive_request;
   logic                                 csr_write_enable;
   logic [tci_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [63:0]                          csr_data;

   // mirror of the curve registers
   logic        cur_mode;
   logic [3:0]  cur_count;
   logic [63:0] cur_x_low, cur_x_high, cur_y_low, cur_y_high;

   longint unsigned weight_table [0:TABLE_DEPTH];
   logic [14:0]     drive_queue [$];
   logic            known_on;
   logic [14:0]     known_value;
   logic            hold_request;
   logic            quiet;
   int              errors;
   int              idle_cycles;
   row_type         rows [$];

   throttle_curve_interpolator_core dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_throttle_position(req_throttle_position),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_drive_request(rsp_drive_request),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   // Q28 taylor series of cos, weight (1-cos)/2 rounded to Q16
   task automatic build_weights();
      longint unsigned angle, angle_sq, term, w;
      longint          c, v;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         angle    = (64'd843314857 * k) / TABLE_DEPTH;
         angle_sq = (angle * angle) >> 28;
         term     = 64'd1 << 28;
         c        = longint'(term);
         for (int n = 1; n <= 14; n++) begin
            term = (term * angle_sq) >> 28;
            term = term / (64'(2 * n - 1) * 64'(2 * n));
            if (n % 2 == 1) c = c - longint'(term);
            else c = c + longint'(term);
         end
         v = (longint'(1) << 28) - c;
         if (v < 0) v = 0;
         w = (unsigned'(v) + 64'd4096) >> 13;
         if (w > 64'd65536) w = 64'd65536;
         weight_table[k] = w;
      end
   endtask

   function automatic longint unsigned point_of(logic [63:0] lo, logic [63:0] hi, int i);
      if (i < 4) return 64'(lo[16*i +: 16]);
      return 64'(hi[16*(i-4) +: 16]);
   endfunction

   function automatic logic [14:0] drive_for(logic [9:0] position);
      longint unsigned pos, y, xl, xh, yl, yh, dx, xd, mu, k, w;
      int n, seg;
      pos = 64'(position);
      n   = int'(cur_count);
      seg = -1;
      if (n < 2) n = 2;
      if (n > 8) n = 8;
      if (pos < point_of(cur_x_low, cur_x_high, 0)) begin
         y = 0;
      end else begin
         for (int i = 0; i < n; i++)
            if (point_of(cur_x_low, cur_x_high, i) < pos) seg = i;
         if (seg < 0) begin
            y = point_of(cur_y_low, cur_y_high, 0);
         end else if (seg == n - 1) begin
            y = point_of(cur_y_low, cur_y_high, seg);
         end else begin
            xl = point_of(cur_x_low, cur_x_high, seg);
            xh = point_of(cur_x_low, cur_x_high, seg + 1);
            yl = point_of(cur_y_low, cur_y_high, seg);
            yh = point_of(cur_y_low, cur_y_high, seg + 1);
            dx = pos - xl;
            xd = xh - xl;
            if (cur_mode == tci_pkg::CURVE_COSINE) begin
               mu = (dx << 16) / xd;
               k  = (mu * TABLE_DEPTH + 64'd32768) >> 16;
               if (k > TABLE_DEPTH) k = TABLE_DEPTH;
               w  = weight_table[k];
               y  = (yl * (64'd65536 - w) + yh * w) >> 16;
            end else begin
               y = (yl * (xd - dx) + yh * dx) / xd;
            end
         end
      end
      if (y > DRIVE_MAX) y = DRIVE_MAX;
      return y[14:0];
   endfunction

   task automatic write_csr(input logic [tci_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [63:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_data         = data;
      case (index)
         tci_pkg::CSR_CURVE_MODE:    cur_mode   = data[0];
         tci_pkg::CSR_POINT_COUNT:   cur_count  = data[3:0];
         tci_pkg::CSR_X_POINTS_LOW:  cur_x_low  = data;
         tci_pkg::CSR_X_POINTS_HIGH: cur_x_high = data;
         tci_pkg::CSR_Y_POINTS_LOW:  cur_y_low  = data;
         tci_pkg::CSR_Y_POINTS_HIGH: cur_y_high = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic wait_idle();
      req_push = 1'b0;
      wait (drive_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // offer one word, return at the negedge after it was taken
   task automatic send_word(input logic [9:0] position, input logic pin, input logic [14:0] pinned);
      logic taken;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_push              = 1'b1;
      req_throttle_position = position;
      known_on              = pin;
      known_value           = pinned;
      do begin
         @(posedge clock);
         taken = !req_full;
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic random_curve(input bit extreme);
      logic [15:0] xs [8];
      logic [63:0] yl, yh;
      int x;
      x = extreme ? 0 : $urandom_range(0, 150);
      for (int i = 0; i < 8; i++) begin
         xs[i] = x[15:0];
         x = x + (extreme ? 146 : $urandom_range(0, 250));
         if (x > 65535) x = 65535;
      end
      if (!extreme && $urandom_range(0, 4) == 0)
         foreach (xs[i]) xs[i] = 16'($urandom);
      yl = {$urandom, $urandom};
      yh = {$urandom, $urandom};
      if (extreme) begin
         yl = '1;
         yh = '0;
      end
      write_csr(tci_pkg::CSR_CURVE_MODE, {$urandom, $urandom});
      write_csr(tci_pkg::CSR_POINT_COUNT, extreme ? 64'd8 :
                64'($urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : $urandom_range(2, 8)));
      write_csr(tci_pkg::CSR_X_POINTS_LOW, {xs[3], xs[2], xs[1], xs[0]});
      write_csr(tci_pkg::CSR_X_POINTS_HIGH, {xs[7], xs[6], xs[5], xs[4]});
      write_csr(tci_pkg::CSR_Y_POINTS_LOW, yl);
      write_csr(tci_pkg::CSR_Y_POINTS_HIGH, yh);
   endtask

   function automatic logic [9:0] random_position();
      int p;
      if ($urandom_range(0, 2) == 0) begin
         p = int'(point_of(cur_x_low, cur_x_high, $urandom_range(0, 7)))
             + $urandom_range(0, 2) - 1;
         return p[9:0];
      end
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic row_type word_row(logic [9:0] position);
      return '{ROW_WORD, position, 15'd0, tci_pkg::CSR_CURVE_MODE, 64'd0};
   endfunction

   function automatic row_type known_row(logic [9:0] position, logic [14:0] drive);
      return '{ROW_WORD_KNOWN, position, drive, tci_pkg::CSR_CURVE_MODE, 64'd0};
   endfunction

   function automatic row_type csr_row(logic [tci_pkg::CSR_INDEX_WIDTH-1:0] index,
                                       logic [63:0] data);
      return '{ROW_CSR, 10'd0, 15'd0, index, data};
   endfunction

   // accepted input words
   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         drive_queue.insert(drive_queue.size(),
                            known_on ? known_value : drive_for(req_throttle_position));
   end

   // accepted result words
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (drive_queue.size() == 0) begin
            report($sformatf("unexpected drive_request %0d", rsp_drive_request));
         end else begin
            if (rsp_drive_request !== drive_queue[0])
               report($sformatf("drive_request %0d, wanted %0d",
                                rsp_drive_request, drive_queue[0]));
            void'(drive_queue.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("throttle_curve_interpolator_core_tb failed");
            $finish;
         end
      end
   end

   // receiver
   initial begin
      rsp_pop = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_pop = 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      req_push              = 1'b0;
      req_throttle_position = '0;
      csr_write_enable      = 1'b0;
      csr_index             = tci_pkg::CSR_CURVE_MODE;
      csr_data              = '0;
      known_on              = 1'b0;
      known_value           = '0;
      hold_request          = 1'b0;
      quiet                 = 1'b0;
      errors                = 0;
      idle_cycles           = 0;
      cur_mode              = tci_pkg::CURVE_LINEAR;
      cur_count             = tci_pkg::POINT_COUNT_RESET;
      cur_x_low             = tci_pkg::X_POINTS_LOW_RESET;
      cur_x_high            = '0;
      cur_y_low             = tci_pkg::Y_POINTS_LOW_RESET;
      cur_y_high            = '0;
      build_weights();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      rows = '{
         known_row(10'd0, 15'd0),
         known_row(10'd1023, 15'd32767),
         word_row(10'd512),
         csr_row(tci_pkg::CSR_CURVE_MODE, 64'd1),
         word_row(10'd512),
         known_row(10'd1023, 15'd32767),
         csr_row(tci_pkg::CSR_X_POINTS_LOW, 64'h0384_02BC_012C_0064),
         csr_row(tci_pkg::CSR_Y_POINTS_LOW, 64'h7FFF_2000_FFFF_03E8),
         csr_row(tci_pkg::CSR_POINT_COUNT, 64'd4),
         known_row(10'd50, 15'd0),            // deadzone
         known_row(10'd100, 15'd1000),        // on the first breakpoint
         known_row(10'd1000, 15'd32767),      // past the last point
         word_row(10'd200),
         word_row(10'd800),
         csr_row(tci_pkg::CSR_CURVE_MODE, 64'd0),
         known_row(10'd300, 15'd32767),       // saturates
         word_row(10'd500),
         csr_row(tci_pkg::CSR_X_POINTS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
         csr_row(tci_pkg::CSR_Y_POINTS_HIGH, 64'h0000_0000_0000_1234),
         csr_row(tci_pkg::CSR_POINT_COUNT, 64'd15),    // clamps to eight
         word_row(10'd1023),
         csr_row(CSR_UNMAPPED_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
         csr_row(CSR_UNMAPPED_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
         word_row(10'd950),
         csr_row(tci_pkg::CSR_POINT_COUNT, 64'd0),     // clamps to two
         word_row(10'd1023)
      };
      foreach (rows[r]) begin
         if (rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(rows[r].index, rows[r].data);
         end else begin
            send_word(rows[r].position, rows[r].kind == ROW_WORD_KNOWN, rows[r].known_drive);
         end
      end

      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         random_curve(phase == 1);
         quiet = (phase >= 8);
         if (phase == 3) hold_request = 1'b1;
         for (int i = 0; i < 140; i++) send_word(random_position(), 1'b0, 15'd0);
      end

      req_push = 1'b0;
      wait (drive_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("throttle_curve_interpolator_core_tb passed");
      end else begin
         $display("throttle_curve_interpolator_core_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
